>>> rtl/vna_pkg.sv
// Package with shared types, constants and helpers for the vertex normal accumulator.
`default_nettype none
package vna_pkg;
  localparam int MAX_VERTS = 1024;
  localparam int IDX_W = $clog2(MAX_VERTS);
  localparam int CNT_W = 11;
  localparam int ACC_W = 48;
  localparam int POS_W = 48;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_TRI   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [IDX_W-1:0]  corner_a;
    logic [IDX_W-1:0]  corner_b;
    logic [IDX_W-1:0]  corner_c;
  } item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [1:0]         status;
  } result_t;

  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t sat_add(input acc_t a, input logic signed [34:0] d);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W-34){d[34]}}, d};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/vna_lane.sv
// One cross-product lane: a 17x17 product difference, registered.
`default_nettype none
module vna_lane (
  input  wire logic               clk,
  input  wire logic signed [16:0] a1,
  input  wire logic signed [16:0] b1,
  input  wire logic signed [16:0] a2,
  input  wire logic signed [16:0] b2,
  output logic signed [34:0]      prod
);
  logic signed [33:0] p1;
  logic signed [33:0] p2;
  always_ff @(posedge clk) begin
    p1 <= a1 * b1;
    p2 <= a2 * b2;
    prod <= 35'(p1) - 35'(p2);
  end
endmodule
`default_nettype wire

>>> rtl/vna_norm.sv
// Sequential normaliser: shift, square sum, square root and three divisions.
`default_nettype none
module vna_norm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire vna_pkg::acc_t  sx,
  input  wire vna_pkg::acc_t  sy,
  input  wire vna_pkg::acc_t  sz,
  output logic                done,
  output vna_pkg::result_t    res
);
  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV, N_OUT} nstate_t;
  nstate_t state;
  logic [47:0] mx, my, mz;
  logic        gx, gy, gz;
  logic [61:0] sq;
  logic [63:0] rem, root, bitv;
  logic [1:0]  comp;
  logic [5:0]  cnt;
  logic [44:0] num;
  logic [44:0] drem;
  logic [15:0] q;
  logic [15:0] qx, qy;
  logic [1:0]  sqstep;
  logic [47:0] mmax;
  logic [63:0] trial;
  logic [45:0] dtry;
  assign mmax = mx | my | mz;
  assign trial = root + bitv;
  assign dtry = {drem, num[44]} - {14'd0, root[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: if (go) begin
          gx <= sx[47]; gy <= sy[47]; gz <= sz[47];
          mx <= sx[47] ? 48'(-sx) : sx;
          my <= sy[47] ? 48'(-sy) : sy;
          mz <= sz[47] ? 48'(-sz) : sz;
          state <= N_SHIFT;
        end
        N_SHIFT: begin
          if (mmax == 48'd0) begin
            res <= '{16'sd0, 16'sd0, 16'sd0, vna_pkg::ST_ZERO};
            state <= N_OUT;
          end else if (mmax[47:30] != 18'd0) begin
            mx <= mx >> 1; my <= my >> 1; mz <= mz >> 1;
          end else begin
            sq <= '0;
            sqstep <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          case (sqstep)
            2'd0: sq <= sq + 62'(mx[29:0] * mx[29:0]);
            2'd1: sq <= sq + 62'(my[29:0] * my[29:0]);
            default: sq <= sq + 62'(mz[29:0] * mz[29:0]);
          endcase
          if (sqstep == 2'd2) begin
            rem <= '0; root <= '0; bitv <= 64'd1 << 62; state <= N_ROOT;
          end
          sqstep <= sqstep + 2'd1;
        end
        N_ROOT: begin
          if (bitv == 64'd0) begin
            comp <= 2'd0; cnt <= '0; drem <= '0; num <= {1'b0, mx[29:0], 14'd0};
            state <= N_DIV;
          end else begin
            if (rem == 64'd0 && root == 64'd0) begin
              rem <= {2'b0, sq};
            end
            if (((rem == 64'd0 && root == 64'd0) ? {2'b0, sq} : rem) >= trial) begin
              rem <= ((rem == 64'd0 && root == 64'd0) ? {2'b0, sq} : rem) - trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        N_DIV: begin
          if (!dtry[45]) begin
            drem <= dtry[44:0];
            q <= {q[14:0], 1'b1};
          end else begin
            drem <= {drem[43:0], num[44]};
            q <= {q[14:0], 1'b0};
          end
          num <= {num[43:0], 1'b0};
          if (cnt == 6'd44) begin
            cnt <= '0; drem <= '0;
            case (comp)
              2'd0: begin
                qx <= {q[14:0], !dtry[45]};
                num <= {1'b0, my[29:0], 14'd0};
                comp <= 2'd1;
              end
              2'd1: begin
                qy <= {q[14:0], !dtry[45]};
                num <= {1'b0, mz[29:0], 14'd0};
                comp <= 2'd2;
              end
              default: begin
                res.normal_x <= gx ? -qx : qx;
                res.normal_y <= gy ? -qy : qy;
                res.normal_z <= gz ? -{q[14:0], !dtry[45]} : {q[14:0], !dtry[45]};
                res.status <= vna_pkg::ST_OK;
                state <= N_OUT;
              end
            endcase
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        N_OUT: begin
          done <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/vertex_normal_accumulator.sv
// Top level: position and accumulator memories, cross-product lanes and control.
// Load, rejected and spare-code items go to the response; triangles read three positions
// and update three accumulators. Queries run up to 18 shift steps, the bit-serial square
// root and three 45-step divisions in the normaliser; a zero-length query skips those two.
// Synchronous active-high reset clears control and vertex_count; stores stay undefined.
// Results appear for one cycle with done; the receiver cannot stall.
`default_nettype none
module vertex_normal_accumulator (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire vna_pkg::item_t           item,
  output logic                          done,
  output vna_pkg::result_t              result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [vna_pkg::CNT_W-1:0] cfg_data
);
  typedef enum logic [3:0] {S_IDLE, S_CHECK, S_RDC, S_RDA, S_RDB, S_LANE, S_ACCR,
                            S_ACCW, S_QRD, S_QWAIT, S_QRUN, S_RESP} state_t;
  state_t state;
  logic [vna_pkg::POS_W-1:0]  pos_mem [vna_pkg::MAX_VERTS];
  logic [3*vna_pkg::ACC_W-1:0] acc_mem [vna_pkg::MAX_VERTS];
  logic [vna_pkg::CNT_W-1:0] vertex_count;
  vna_pkg::item_t it;
  logic [vna_pkg::POS_W-1:0] prd;
  logic [3*vna_pkg::ACC_W-1:0] ard;
  logic [vna_pkg::POS_W-1:0] pc, pa;
  logic signed [16:0] ux, uy, uz, wx, wy, wz;
  logic signed [34:0] cx, cy, cz;
  logic [1:0] k;
  logic [2:0] lw;
  logic [vna_pkg::IDX_W-1:0] raddr, waddr;
  logic [vna_pkg::POS_W-1:0] pwd;
  logic pwe, awe;
  logic [3*vna_pkg::ACC_W-1:0] awd;
  logic ngo, ndone;
  vna_pkg::result_t nres;
  logic [vna_pkg::IDX_W-1:0] cur;

  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (pwe) pos_mem[waddr] <= pwd;
    if (awe) acc_mem[waddr] <= awd;
    prd <= pos_mem[raddr];
    ard <= acc_mem[raddr];
  end

  vna_lane u_lx (.clk(clk), .a1(uy), .b1(wz), .a2(uz), .b2(wy), .prod(cx));
  vna_lane u_ly (.clk(clk), .a1(uz), .b1(wx), .a2(ux), .b2(wz), .prod(cy));
  vna_lane u_lz (.clk(clk), .a1(ux), .b1(wy), .a2(uy), .b2(wx), .prod(cz));

  vna_norm u_norm (.clk(clk), .rst(rst), .go(ngo), .sx(ard[143:96]), .sy(ard[95:48]),
                   .sz(ard[47:0]), .done(ndone), .res(nres));

  always_comb begin
    case (k)
      2'd0: cur = it.corner_a;
      2'd1: cur = it.corner_b;
      default: cur = it.corner_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      vertex_count <= '0;
      pwe <= 1'b0; awe <= 1'b0; ngo <= 1'b0;
    end else begin
      done <= 1'b0; pwe <= 1'b0; awe <= 1'b0; ngo <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) vertex_count <= cfg_data;
          if (start) begin
            it <= item;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          result <= '{16'sd0, 16'sd0, 16'sd0, vna_pkg::ST_OK};
          case (it.func)
            vna_pkg::FUNC_LOAD: begin
              if ({1'b0, it.vertex_index} < vertex_count) begin
                waddr <= it.vertex_index;
                pwd <= {it.pos_x, it.pos_y, it.pos_z};
                awd <= '0; pwe <= 1'b1; awe <= 1'b1;
              end else result.status <= vna_pkg::ST_RANGE;
              state <= S_RESP;
            end
            vna_pkg::FUNC_TRI: begin
              if ({1'b0, it.corner_a} < vertex_count && {1'b0, it.corner_b} < vertex_count
                  && {1'b0, it.corner_c} < vertex_count) begin
                raddr <= it.corner_c;
                state <= S_RDC;
              end else begin
                result.status <= vna_pkg::ST_RANGE;
                state <= S_RESP;
              end
            end
            vna_pkg::FUNC_QUERY: begin
              if ({1'b0, it.vertex_index} < vertex_count) begin
                raddr <= it.vertex_index;
                state <= S_QRD;
              end else begin
                result.status <= vna_pkg::ST_RANGE;
                state <= S_RESP;
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_RDC: begin raddr <= it.corner_a; state <= S_RDA; end
        S_RDA: begin pc <= prd; raddr <= it.corner_b; state <= S_RDB; end
        S_RDB: begin pa <= prd; state <= S_LANE; lw <= '0; end
        S_LANE: begin
          if (lw == 3'd0) begin
            ux <= 17'(signed'(pa[47:32])) - 17'(signed'(pc[47:32]));
            uy <= 17'(signed'(pa[31:16])) - 17'(signed'(pc[31:16]));
            uz <= 17'(signed'(pa[15:0])) - 17'(signed'(pc[15:0]));
            wx <= 17'(signed'(prd[47:32])) - 17'(signed'(pc[47:32]));
            wy <= 17'(signed'(prd[31:16])) - 17'(signed'(pc[31:16]));
            wz <= 17'(signed'(prd[15:0])) - 17'(signed'(pc[15:0]));
          end
          lw <= lw + 3'd1;
          if (lw == 3'd3) begin
            k <= 2'd0; raddr <= it.corner_a; state <= S_ACCR;
          end
        end
        S_ACCR: state <= S_ACCW;
        S_ACCW: begin
          waddr <= cur;
          awd <= {vna_pkg::sat_add(ard[143:96], cx), vna_pkg::sat_add(ard[95:48], cy),
                  vna_pkg::sat_add(ard[47:0], cz)};
          awe <= 1'b1;
          if (k == 2'd2) state <= S_RESP;
          else begin
            k <= k + 2'd1;
            raddr <= (k == 2'd0) ? it.corner_b : it.corner_c;
            state <= S_QWAIT;
          end
        end
        S_QWAIT: state <= S_ACCR;
        S_QRD: begin state <= S_QRUN; lw <= '0; end
        S_QRUN: begin
          if (lw == 3'd0) begin ngo <= 1'b1; lw <= 3'd1; end
          if (ndone) begin result <= nres; state <= S_RESP; end
        end
        S_RESP: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !$past(done));
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item not taken");
  assert property (@(posedge clk) disable iff (rst) done |-> result.status != 2'd3)
    else $error("bad status");
endmodule
`default_nettype wire
